// ===== src/dws_pkg.sv =====
// shared types and constants for the deque with search block
// no dependencies; imported by dws_ram users and deque_with_search_core
package dws_pkg;

  localparam int DEPTH_DEF  = 16;
  localparam int DATA_W     = 32;
  localparam int CMD_W      = 3;
  localparam int STATUS_W   = 2;
  localparam int POS_W      = 5;
  // removed_value, position, fill_count, padded to whole bytes
  localparam int M_TDATA_W  = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_END   = 3'd1,
    CMD_REM_FRONT = 3'd2,
    CMD_REM_END   = 3'd3,
    CMD_SEARCH    = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_SCAN,
    S_PUSH
  } state_e;

endpackage

// ===== src/dws_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module dws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== src/deque_with_search_core.sv =====
// bounded double-ended queue of 32-bit values with linear search
// depends on dws_pkg and dws_ram
//
// Input channel (s_axis): tuser carries the command (insert front, insert end,
// remove front, remove end, search), tdata the value. Output channel (m_axis):
// one result per input transfer, tuser carries the status, tdata the removed
// value, the match position and the fill count after the command.
// The entries live in a DEPTH-entry ring ram with registered read data;
// front index and entry count are registers.
// Inserts, failed commands and unused codes finish in the accept cycle, so
// the result goes to the output register when that is free; a new transfer
// is taken every cycle while the output does not stall. Removals read the
// ram once; a search reads one entry per cycle from the front, bounded by
// the single ram read port. Neither takes a new transfer until it is done.
// Reset empties the queue at once (front and count cleared, no clearing pass;
// ram contents are not touched). When the receiver stalls, the result waits in
// the output register while the next item is worked on; that result is held
// in a second register and no further transfer is taken until the output drains.
module deque_with_search_core #(
  parameter int DEPTH = dws_pkg::DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [dws_pkg::DATA_W-1:0]  s_axis_tdata,   // [31:0] value
  input  logic [dws_pkg::CMD_W-1:0]   s_axis_tuser,   // [2:0] cmd
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [dws_pkg::M_TDATA_W-1:0] m_axis_tdata, // [31:0] removed_value,
                                                      // [36:32] position,
                                                      // [41:37] fill_count
  output logic [dws_pkg::STATUS_W-1:0] m_axis_tuser   // [1:0] status
);

  import dws_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W:0]   DEPTH_X  = (CNT_W + 1)'(DEPTH);

  // ring slot of base + off, off below DEPTH
  function automatic logic [IDX_W-1:0] slot_at(input logic [IDX_W-1:0] base,
                                               input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
    if (sum >= DEPTH_X) begin
      sum = sum - DEPTH_X;
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] to_pos(input logic [CNT_W-1:0] v);
    logic [CNT_W+POS_W-1:0] ext;
    ext = {{POS_W{1'b0}}, v};
    return ext[POS_W-1:0];
  endfunction

  state_e state_q, state_d;
  logic [IDX_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] off_q, off_d;
  logic [IDX_W-1:0] slot_q, slot_d;
  logic [DATA_W-1:0] val_q, val_d;

  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic              res_valid;
  status_e           res_status;
  logic [DATA_W-1:0] res_removed;
  logic [CNT_W-1:0]  res_pos, res_fill;

  status_e           pend_status_q;
  logic [DATA_W-1:0] pend_removed_q;
  logic [CNT_W-1:0]  pend_pos_q, pend_fill_q;

  logic              out_valid_q, out_valid_d;
  status_e           out_status_q;
  logic [DATA_W-1:0] out_removed_q;
  logic [POS_W-1:0]  out_pos_q, out_fill_q;

  logic       accept, out_free, hit, scan_last, is_full, is_empty;
  cmd_e       in_cmd;
  logic [IDX_W-1:0] prev_front, next_slot;

  assign in_cmd     = cmd_e'(s_axis_tuser);
  assign accept     = s_axis_tvalid && s_axis_tready;
  assign out_free   = !out_valid_q || m_axis_tready;
  assign hit        = (ram_rdata == val_q);
  assign scan_last  = ((CNT_W'(off_q) + 1'b1) == count_q);
  assign is_full    = (count_q == FULL_CNT);
  assign is_empty   = (count_q == '0);
  assign prev_front = (front_q == '0) ? LAST_IDX : front_q - 1'b1;
  assign next_slot  = (slot_q == LAST_IDX) ? '0 : slot_q + 1'b1;

  dws_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(s_axis_tdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // datapath and ram control
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    res_valid   = 1'b0;
    res_status  = ST_OK;
    res_removed = '0;
    res_pos     = '0;
    res_fill    = count_q;
    front_d     = front_q;
    count_d     = count_q;
    off_d       = off_q;
    slot_d      = slot_q;
    val_d       = val_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_INS_FRONT: begin
              res_valid = 1'b1;
              if (is_full) begin
                res_status = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = prev_front;
                front_d   = prev_front;
                count_d   = count_q + 1'b1;
                res_fill  = count_q + 1'b1;
              end
            end
            CMD_INS_END: begin
              res_valid = 1'b1;
              if (is_full) begin
                res_status = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = slot_at(front_q, count_q);
                count_d   = count_q + 1'b1;
                res_fill  = count_q + 1'b1;
              end
            end
            CMD_REM_FRONT: begin
              if (is_empty) begin
                res_valid  = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = front_q;
                front_d   = slot_at(front_q, CNT_W'(1));
                count_d   = count_q - 1'b1;
              end
            end
            CMD_REM_END: begin
              if (is_empty) begin
                res_valid  = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = slot_at(front_q, count_q - 1'b1);
                count_d   = count_q - 1'b1;
              end
            end
            CMD_SEARCH: begin
              if (is_empty) begin
                res_valid  = 1'b1;
                res_status = ST_NOTFOUND;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = front_q;
                slot_d    = front_q;
                off_d     = '0;
                val_d     = s_axis_tdata;
              end
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end
      S_RD: begin
        res_valid   = 1'b1;
        res_removed = ram_rdata;
      end
      S_SCAN: begin
        // ram_rdata holds the entry at offset off_q
        if (hit) begin
          res_valid = 1'b1;
          res_pos   = CNT_W'(off_q) + 1'b1;
        end else if (scan_last) begin
          res_valid  = 1'b1;
          res_status = ST_NOTFOUND;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = next_slot;
          slot_d    = next_slot;
          off_d     = off_q + 1'b1;
        end
      end
      S_PUSH: begin
        res_valid   = 1'b1;
        res_status  = pend_status_q;
        res_removed = pend_removed_q;
        res_pos     = pend_pos_q;
        res_fill    = pend_fill_q;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && !res_valid) begin
          state_d = (in_cmd inside {CMD_REM_FRONT, CMD_REM_END}) ? S_RD : S_SCAN;
        end else if (res_valid && !out_free) begin
          state_d = S_PUSH;
        end
      end
      S_RD: begin
        state_d = out_free ? S_IDLE : S_PUSH;
      end
      S_SCAN: begin
        if (res_valid) begin
          state_d = out_free ? S_IDLE : S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = (res_valid && out_free) ? 1'b1 :
                       (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q  <= off_d;
    slot_q <= slot_d;
    val_q  <= val_d;
    if (res_valid && out_free) begin
      out_status_q  <= res_status;
      out_removed_q <= res_removed;
      out_pos_q     <= to_pos(res_pos);
      out_fill_q    <= to_pos(res_fill);
    end
    if (res_valid && !out_free && state_q != S_PUSH) begin
      pend_status_q  <= res_status;
      pend_removed_q <= res_removed;
      pend_pos_q     <= res_pos;
      pend_fill_q    <= res_fill;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {{(M_TDATA_W - DATA_W - 2 * POS_W){1'b0}},
                          out_fill_q, out_pos_q, out_removed_q};

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("entry count above depth");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> CNT_W'(off_q) < count_q)
    else $error("search offset beyond queued entries");

  a_ram_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == S_IDLE && accept)
    else $error("ring write outside an accepted insert");

  a_remove_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !is_empty && (in_cmd == CMD_REM_FRONT || in_cmd == CMD_REM_END)
    |=> count_q == $past(count_q) - 1'b1)
    else $error("removal did not shrink the queue");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q != ST_OK |-> out_removed_q == '0 && out_pos_q == '0)
    else $error("failed command reports data");

endmodule
